FILE: hdl/wps_pkg.sv
// Package with the shared types and constants of the wildcard pattern search core.
package wps_pkg;

   localparam int PATTERN_MAX_DEFAULT = 16;
   localparam longint TEXT_MAX_DEFAULT = 64'd65536;
   localparam int REG_BYTES = 16;
   localparam int SEEN_W = 17;
   localparam int POS_W = 16;
   localparam int LEN_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_WILDCARD_MASK  = 2'd2,
      CSR_PATTERN_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] match_position;
   } rsp_type;

   typedef struct packed {
      logic [8*REG_BYTES-1:0] pattern;
      logic [REG_BYTES-1:0]   mask;
      logic [LEN_W-1:0]       used_len;
   } cfg_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

FILE: hdl/wps_cell.sv
// One window cell: holds a text byte, shifts it on, tests byte_in against its pattern byte.
module wps_cell
   import wps_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  cfg_type       cfg,
   input  logic [7:0]    byte_in,
   output logic [7:0]    byte_out,
   output logic          miss
);

   localparam logic [6:0] INDEX_W7 = 7'(INDEX);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_next;
   logic       in_use;
   logic [4:0] pat_index_full;
   logic [3:0] pat_index;
   logic [7:0] pat_byte;

   always_comb begin
      in_use = INDEX_W7 < {2'b00, cfg.used_len};
      pat_index_full = cfg.used_len - 5'd1 - INDEX_W7[4:0];
      pat_index = pat_index_full[3:0];
      pat_byte = cfg.pattern[pat_index*8 +: 8];
      miss = in_use && !cfg.mask[pat_index] && (pat_byte != byte_in);
   end

   always_comb begin
      byte_in_next = byte_ff;
      if (ctrl.shift) begin
         byte_in_next = ctrl.clear ? 8'd0 : byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in_next;
      end
   end

   assign byte_out = byte_ff;

endmodule

FILE: hdl/wildcard_pattern_search_core.sv
// Top level of the wildcard pattern search core: registers, window cell chain and result stage.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   text_byte, last_byte
//   rsp      out        rsp_valid/rsp_ready   found, match_position
//   csr      in         csr_write             csr_index, csr_data
//
// One request is taken per cycle while req_ready is high; the window cells compare the
// incoming byte in the same cycle and the result is registered in the output stage.
// Reset clears the window, byte count, reported flag, pattern and mask, and sets length to 1.
// A request is taken while the output stage is empty or being drained, so a stall
// on rsp holds req only while a result is waiting.
module wildcard_pattern_search_core
   import wps_pkg::*;
#(
   parameter int     PATTERN_MAX = PATTERN_MAX_DEFAULT,
   parameter longint TEXT_MAX    = TEXT_MAX_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int LEN_CAP = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
   localparam longint START_LIMIT_L = (TEXT_MAX - 1 < 65535) ? TEXT_MAX - 1 : 65535;
   localparam logic [SEEN_W-1:0] START_LIMIT = SEEN_W'(START_LIMIT_L);
   localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

   logic [63:0]            pattern_low_ff;
   logic [63:0]            pattern_high_ff;
   logic [REG_BYTES-1:0]   mask_ff;
   logic [LEN_W-1:0]       length_ff;
   logic [SEEN_W-1:0]      seen_ff;
   logic [SEEN_W-1:0]      seen_in;
   logic                   reported_ff;
   logic                   reported_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   cfg_type                cfg;
   cell_ctrl_type          ctrl;
   logic [7:0]             chain [PATTERN_MAX+1];
   logic [PATTERN_MAX-1:0] miss;
   logic [REG_BYTES-1:0]   len_bits;
   logic                   literal;
   logic                   fire;
   logic [SEEN_W-1:0]      seen_next;
   logic [SEEN_W-1:0]      start;
   logic                   hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff <= '0;
         pattern_high_ff <= '0;
         mask_ff <= '0;
         length_ff <= LEN_W'(1);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:    pattern_low_ff <= csr_data;
            CSR_PATTERN_HIGH:   pattern_high_ff <= csr_data;
            CSR_WILDCARD_MASK:  mask_ff <= csr_data[REG_BYTES-1:0];
            CSR_PATTERN_LENGTH: length_ff <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.pattern = {pattern_high_ff, pattern_low_ff};
      cfg.mask = mask_ff;
      cfg.used_len = (length_ff > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : length_ff;
      for (int i = 0; i < REG_BYTES; i++) begin
         len_bits[i] = LEN_W'(i) < cfg.used_len;
      end
      literal = |(~mask_ff & len_bits);
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire = req_valid && req_ready;
   assign ctrl.shift = fire;
   assign ctrl.clear = req_data.last_byte;
   assign chain[0] = req_data.text_byte;

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      wps_cell #(
         .INDEX(j)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .cfg     (cfg),
         .byte_in (chain[j]),
         .byte_out(chain[j+1]),
         .miss    (miss[j])
      );
   end

   always_comb begin
      seen_next = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + SEEN_W'(1);
      start = seen_next - SEEN_W'(cfg.used_len);
      hit = !reported_ff && (cfg.used_len != '0) && (seen_next >= SEEN_W'(cfg.used_len))
            && literal && !(|miss) && (start <= START_LIMIT);

      seen_in = seen_ff;
      reported_in = reported_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      if (fire) begin
         if (hit || (req_data.last_byte && !reported_ff)) begin
            rsp_valid_in = 1'b1;
            rsp_in.found = hit;
            rsp_in.match_position = hit ? start[POS_W-1:0] : '0;
         end
         if (req_data.last_byte) begin
            seen_in = '0;
            reported_in = 1'b0;
         end else begin
            seen_in = seen_next;
            reported_in = reported_ff || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         reported_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         reported_ff <= reported_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_hit_sets_reported: assert property (@(posedge clock) disable iff (reset)
      fire && hit && !req_data.last_byte |=> reported_ff)
      else $error("match did not mark the text as reported");

   a_last_clears_count: assert property (@(posedge clock) disable iff (reset)
      fire && req_data.last_byte |=> seen_ff == '0 && !reported_ff)
      else $error("end of text did not clear the text state");

   a_not_found_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.found |-> rsp_ff.match_position == '0)
      else $error("not found result carries a nonzero position");

   a_no_hit_after_report: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> !hit)
      else $error("second match reported within one text");

endmodule

FILE: tb/sv/tb_wildcard_pattern_search_core.sv
// Testbench for the wildcard pattern search core with a built-in predictor and result checker.
module tb_wildcard_pattern_search_core;
   timeunit 1ns;
   timeprecision 1ps;

   import wps_pkg::*;

   typedef logic [7:0] byte_queue_type [$];

   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 8;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Shadow copy of the registers and the text state.
   logic [63:0]       cfg_pattern_low = '0;
   logic [63:0]       cfg_pattern_high = '0;
   logic [15:0]       cfg_wildcards = '0;
   logic [LEN_W-1:0]  cfg_length = 5'd1;
   logic [7:0]        window [PATTERN_MAX_DEFAULT] = '{default: 8'h00};
   logic [SEEN_W-1:0] seen_count = '0;
   logic              reported = 1'b0;

   rsp_type pending_matches [$];
   int      mismatch_count = 0;
   int      items_sent = 0;
   int      sender_idle_pct = 0;
   int      receiver_idle_pct = 0;
   int      rsp_hold_cycles = 0;
   int      stall_cycles = 0;

   wildcard_pattern_search_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int active_length();
      int cap;
      int len;
      cap = (PATTERN_MAX_DEFAULT < REG_BYTES) ? PATTERN_MAX_DEFAULT : REG_BYTES;
      len = int'(cfg_length);
      return (len > cap) ? cap : len;
   endfunction

   task automatic search_step(input logic [7:0] text_byte, input logic last);
      int                len;
      logic [127:0]      pattern;
      logic              hit;
      logic              literal;
      logic [SEEN_W-1:0] start;
      rsp_type           result;
      len = active_length();
      pattern = {cfg_pattern_high, cfg_pattern_low};
      for (int i = PATTERN_MAX_DEFAULT - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = text_byte;
      if (seen_count != '1) seen_count++;
      if (!reported && len > 0 && seen_count >= len) begin
         start = seen_count - SEEN_W'(len);
         hit = 1'b1;
         literal = 1'b0;
         for (int i = 0; i < len; i++) begin
            if (!cfg_wildcards[i]) begin
               literal = 1'b1;
               if (pattern[8*i +: 8] != window[len-1-i]) hit = 1'b0;
            end
         end
         if (hit && literal && start < TEXT_MAX_DEFAULT && start <= 17'h0FFFF) begin
            result.found = 1'b1;
            result.match_position = start[POS_W-1:0];
            pending_matches.push_back(result);
            reported = 1'b1;
         end
      end
      if (last) begin
         if (!reported) begin
            result.found = 1'b0;
            result.match_position = '0;
            pending_matches.push_back(result);
         end
         for (int i = 0; i < PATTERN_MAX_DEFAULT; i++) window[i] = 8'h00;
         seen_count = '0;
         reported = 1'b0;
      end
   endtask

   task automatic push_text_byte(input logic [7:0] text_byte, input logic last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{text_byte: text_byte, last_byte: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      search_step(text_byte, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input byte_queue_type text);
      for (int i = 0; i < text.size(); i++) push_text_byte(text[i], i == text.size() - 1);
   endtask

   function automatic byte_queue_type to_bytes(input string s);
      byte_queue_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   task automatic write_csr(input csr_index_type index, input logic [63:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      case (index)
         CSR_PATTERN_LOW:    cfg_pattern_low = value;
         CSR_PATTERN_HIGH:   cfg_pattern_high = value;
         CSR_WILDCARD_MASK:  cfg_wildcards = value[15:0];
         CSR_PATTERN_LENGTH: cfg_length = value[LEN_W-1:0];
         default:            ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_pattern(input string p, input logic [15:0] mask, input logic [4:0] len);
      logic [127:0] bytes;
      bytes = '0;
      for (int i = 0; i < p.len() && i < REG_BYTES; i++) bytes[8*i +: 8] = p[i];
      write_csr(CSR_PATTERN_LOW, bytes[63:0]);
      write_csr(CSR_PATTERN_HIGH, bytes[127:64]);
      write_csr(CSR_WILDCARD_MASK, {48'd0, mask});
      write_csr(CSR_PATTERN_LENGTH, {59'd0, len});
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_matches.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 4))
            0:       return "a";
            1:       return "b";
            2:       return "?";
            3:       return 8'h00;
            default: return 8'hFF;
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic randomize_pattern();
      logic [127:0] bytes;
      logic [15:0]  mask;
      int           choice;
      for (int i = 0; i < REG_BYTES; i++) bytes[8*i +: 8] = pick_byte();
      case ($urandom_range(0, 5))
         0:       mask = '0;
         1:       mask = '1;
         2:       mask = 16'($urandom_range(0, 65535));
         default: mask = 16'($urandom_range(0, 65535) & $urandom_range(0, 65535));
      endcase
      write_csr(CSR_PATTERN_LOW, bytes[63:0]);
      write_csr(CSR_PATTERN_HIGH, bytes[127:64]);
      write_csr(CSR_WILDCARD_MASK, {48'd0, mask});
      choice = $urandom_range(0, 19);
      if (choice == 0) write_csr(CSR_PATTERN_LENGTH, 64'd0);
      else if (choice == 1) write_csr(CSR_PATTERN_LENGTH, 64'd16);
      else if (choice == 2) write_csr(CSR_PATTERN_LENGTH, 64'($urandom_range(17, 31)));
      else write_csr(CSR_PATTERN_LENGTH, 64'($urandom_range(1, 6)));
   endtask

   function automatic byte_queue_type random_text();
      byte_queue_type q;
      logic [127:0]   pattern;
      int             len;
      int             kind;
      int             copy_len;
      pattern = {cfg_pattern_high, cfg_pattern_low};
      len = active_length();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(1, 30)) q.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 20)) q.push_back(pick_byte());
         copy_len = (kind == 1 && len > 0) ? $urandom_range(0, len - 1) : len;
         for (int i = 0; i < copy_len; i++)
            q.push_back(cfg_wildcards[i] ? pick_byte() : pattern[8*i +: 8]);
         repeat ($urandom_range(0, 10)) q.push_back(pick_byte());
      end
      if (q.size() == 0) q.push_back(pick_byte());
      return q;
   endfunction

   task automatic test_reset_values();
      byte_queue_type q;
      q = '{8'h00};
      send_text(q);
      q = '{8'hFF, 8'h00};
      send_text(q);
      settle();
   endtask

   task automatic test_wildcard_and_literal();
      set_pattern("a?c", 16'h0002, 5'd3);
      send_text(to_bytes("xabc"));
      settle();
      set_pattern("?", 16'h0000, 5'd1);
      send_text(to_bytes("a?"));
      settle();
   endtask

   task automatic test_leading_wildcard();
      set_pattern("?b", 16'h0001, 5'd2);
      send_text(to_bytes("b"));
      send_text(to_bytes("ab"));
      settle();
   endtask

   task automatic test_only_wildcards();
      set_pattern("ab", 16'hFFFF, 5'd2);
      send_text(to_bytes("abc"));
      settle();
   endtask

   task automatic test_length_bounds();
      byte_queue_type q;
      set_pattern("a", 16'h0000, 5'd0);
      send_text(to_bytes("a"));
      settle();
      write_csr(CSR_PATTERN_LOW, '1);
      write_csr(CSR_PATTERN_HIGH, '1);
      write_csr(CSR_WILDCARD_MASK, 64'd0);
      write_csr(CSR_PATTERN_LENGTH, 64'd31);
      repeat (16) q.push_back(8'hFF);
      send_text(q);
      settle();
   endtask

   task automatic test_after_report();
      set_pattern("a", 16'h0000, 5'd1);
      send_text(to_bytes("aaa"));
      settle();
   endtask

   task automatic test_output_stall();
      set_pattern("ab", 16'h0000, 5'd2);
      rsp_hold_cycles = 400;
      repeat (6) send_text(to_bytes("ab"));
      settle();
   endtask

   task automatic test_random_texts(input int send_pct, input int recv_pct, input int count);
      int target;
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(0, 2) == 0) begin
            settle();
            randomize_pattern();
         end
         send_text(random_text());
      end
      settle();
   endtask

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_matches.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: found=%0b pos=%0d",
                        rsp_data.found, rsp_data.match_position);
         end else begin
            want = pending_matches.pop_front();
            if (want.found != rsp_data.found ||
                want.match_position != rsp_data.match_position) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected found=%0b pos=%0d, got found=%0b pos=%0d",
                           want.found, want.match_position,
                           rsp_data.found, rsp_data.match_position);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_values();
      test_wildcard_and_literal();
      test_leading_wildcard();
      test_only_wildcards();
      test_length_bounds();
      test_after_report();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_output_stall();
      test_random_texts(30, 78, 570);
      test_random_texts(78, 30, 570);
      test_random_texts(0, 0, 570);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
